// ----- rtl/owd_pkg.sv -----
package owd_pkg;

  typedef enum logic [1:0] {
    MODE_NONE       = 2'd0,
    MODE_ANTIFREEZE = 2'd1,
    MODE_COMFORT    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_COMFORT    = 3'd1,
    REG_ANTIFREEZE = 3'd2,
    REG_TRIGGER    = 3'd3,
    REG_OPEN       = 3'd4,
    REG_CLOSE      = 3'd5,
    REG_SAMPLE     = 3'd6,
    REG_WATCH      = 3'd7
  } reg_idx_t;

  localparam int TEMP_W  = 11;
  localparam int DELTA_W = 10;
  localparam int TICK_W  = 16;
  localparam int VAIN_W  = 8;
  localparam int TGT_W   = 8;
  // baseline minus temperature spans 12 bits signed; one more for the delta compare
  localparam int DIFF_W  = 13;

  localparam logic [DIFF_W-1:0] VAIN_DROP_LIMIT  = 13'sd20;
  localparam logic [VAIN_W-1:0] VAIN_COUNT_LIMIT = 8'd5;
  localparam logic [TICK_W-1:0] TICK_RESET       = 16'd880;

  localparam logic [TGT_W-1:0]   RST_COMFORT    = 8'd0;
  localparam logic [TGT_W-1:0]   RST_ANTIFREEZE = 8'd7;
  localparam logic [DELTA_W-1:0] RST_TRIGGER    = 10'd10;
  localparam logic [DELTA_W-1:0] RST_OPEN       = 10'd50;
  localparam logic [DELTA_W-1:0] RST_CLOSE      = 10'd50;
  localparam logic [TICK_W-1:0]  RST_SAMPLE     = 16'd960;
  localparam logic [TICK_W-1:0]  RST_WATCH      = 16'd14400;

  typedef struct packed {
    logic               enable;
    logic [TGT_W-1:0]   comfort_target;
    logic [TGT_W-1:0]   antifreeze_target;
    logic [DELTA_W-1:0] trigger_delta;
    logic [DELTA_W-1:0] open_delta;
    logic [DELTA_W-1:0] close_delta;
    logic [TICK_W-1:0]  sample_ticks;
    logic [TICK_W-1:0]  watch_ticks;
  } cfg_t;

  typedef struct packed {
    logic                     open_flag;
    logic                     watching;
    logic [TICK_W-1:0]        tick_count;
    logic signed [TEMP_W-1:0] baseline;
    logic [VAIN_W-1:0]        vain_count;
  } state_t;

  typedef struct packed {
    logic [TGT_W-1:0] new_target;
    mode_t            mode_change;
    logic             window_is_open;
  } result_t;

endpackage

// ----- rtl/open_window_detector_top.sv -----
// Open-window detector for a thermostat. Each input item is a timer tick
// (in_tuser low) or a request to take the item's temperature as the new
// baseline (in_tuser high); every item yields exactly one result item with
// the open-window verdict and, when the verdict changes, the mode to switch
// to and its target temperature. An item is taken every clock cycle: the
// whole detector update is combinational logic between the detector state
// registers and a two-entry output stage, so a stalled output side holds
// in_tready low only once both output entries are full. Registers must be
// written through the cfg_ port while no item is in flight; the block does not enforce it.
module open_window_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // temperature[10:0], heater_on[11], zero[15:12]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // window_is_open[0], mode_change[2:1], new_target[10:3], zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  owd_pkg::cfg_t    cfg_r;
  owd_pkg::state_t  st_r;
  owd_pkg::state_t  st_nxt;
  owd_pkg::result_t res;
  owd_pkg::result_t out_r;
  owd_pkg::result_t skid_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             in_acc;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable            <= 1'b0;
      cfg_r.comfort_target    <= owd_pkg::RST_COMFORT;
      cfg_r.antifreeze_target <= owd_pkg::RST_ANTIFREEZE;
      cfg_r.trigger_delta     <= owd_pkg::RST_TRIGGER;
      cfg_r.open_delta        <= owd_pkg::RST_OPEN;
      cfg_r.close_delta       <= owd_pkg::RST_CLOSE;
      cfg_r.sample_ticks      <= owd_pkg::RST_SAMPLE;
      cfg_r.watch_ticks       <= owd_pkg::RST_WATCH;
    end else if (cfg_we) begin
      case (owd_pkg::reg_idx_t'(cfg_addr))
        owd_pkg::REG_ENABLE:     cfg_r.enable            <= cfg_wdata[0];
        owd_pkg::REG_COMFORT:    cfg_r.comfort_target    <= cfg_wdata[7:0];
        owd_pkg::REG_ANTIFREEZE: cfg_r.antifreeze_target <= cfg_wdata[7:0];
        owd_pkg::REG_TRIGGER:    cfg_r.trigger_delta     <= cfg_wdata[9:0];
        owd_pkg::REG_OPEN:       cfg_r.open_delta        <= cfg_wdata[9:0];
        owd_pkg::REG_CLOSE:      cfg_r.close_delta       <= cfg_wdata[9:0];
        owd_pkg::REG_SAMPLE:     cfg_r.sample_ticks      <= cfg_wdata;
        owd_pkg::REG_WATCH:      cfg_r.watch_ticks       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  owd_update u_update (
    .cfg         (cfg_r),
    .st          (st_r),
    .action      (in_tuser),
    .temperature (in_tdata[10:0]),
    .heater_on   (in_tdata[11]),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.open_flag  <= 1'b0;
      st_r.watching   <= 1'b0;
      st_r.tick_count <= owd_pkg::TICK_RESET;
      st_r.baseline   <= '0;
      st_r.vain_count <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_valid_r && out_tready) begin
      // advance the held item into the output slot
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!out_valid_r || out_tready) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (out_valid_r && out_tready && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_r.new_target, out_r.mode_change, out_r.window_is_open};

endmodule

// ----- rtl/owd_update.sv -----
module owd_update (
  input  owd_pkg::cfg_t                      cfg,
  input  owd_pkg::state_t                    st,
  input  logic                               action,
  input  logic signed [owd_pkg::TEMP_W-1:0]  temperature,
  input  logic                               heater_on,
  output owd_pkg::state_t                    st_nxt,
  output owd_pkg::result_t                   res
);

  logic signed [owd_pkg::DIFF_W-1:0] drop;
  logic signed [owd_pkg::DIFF_W-1:0] rise;
  logic signed [owd_pkg::DIFF_W-1:0] trig_s;
  logic signed [owd_pkg::DIFF_W-1:0] open_s;
  logic signed [owd_pkg::DIFF_W-1:0] close_s;
  logic                              verdict;
  logic                              trig_hit;
  logic                              vain_hit;
  logic [owd_pkg::VAIN_W-1:0]        vain_new;
  owd_pkg::mode_t                    mode;
  logic [owd_pkg::TGT_W-1:0]         target;

  assign drop    = owd_pkg::DIFF_W'(st.baseline) - owd_pkg::DIFF_W'(temperature);
  assign rise    = owd_pkg::DIFF_W'(temperature) - owd_pkg::DIFF_W'(st.baseline);
  assign trig_s  = $signed({3'b000, cfg.trigger_delta});
  assign open_s  = $signed({3'b000, cfg.open_delta});
  assign close_s = $signed({3'b000, cfg.close_delta});

  always_comb begin
    st_nxt   = st;
    mode     = owd_pkg::MODE_NONE;
    target   = '0;
    verdict  = 1'b0;
    trig_hit = 1'b0;
    vain_hit = 1'b0;
    vain_new = st.vain_count;
    if (action) begin
      st_nxt.baseline = temperature;
    end else if (cfg.enable) begin
      if (st.watching) begin
        if (st.tick_count < cfg.watch_ticks) begin
          verdict = st.open_flag ? (rise > close_s) : (drop > open_s);
          if (verdict) begin
            st_nxt.open_flag = !st.open_flag;
            st_nxt.baseline  = temperature;
            st_nxt.watching  = 1'b0;
            mode   = st.open_flag ? owd_pkg::MODE_COMFORT : owd_pkg::MODE_ANTIFREEZE;
            target = st.open_flag ? cfg.comfort_target : cfg.antifreeze_target;
            st_nxt.tick_count = owd_pkg::TICK_W'(1);
          end else begin
            st_nxt.tick_count = st.tick_count + 1'b1;
          end
        end else begin
          // window expired: restart from the present temperature
          st_nxt.baseline   = temperature;
          st_nxt.watching   = 1'b0;
          st_nxt.tick_count = '0;
        end
      end else if (st.tick_count < cfg.sample_ticks) begin
        st_nxt.tick_count = st.tick_count + 1'b1;
      end else begin
        trig_hit = st.open_flag ? (rise > trig_s) : (drop > trig_s);
        if (trig_hit) begin
          st_nxt.watching = 1'b1;
        end else begin
          st_nxt.baseline = temperature;
        end
        st_nxt.tick_count = '0;
        if (!st.open_flag) begin
          // a fresh baseline equals the temperature, so the drop is zero
          vain_hit = heater_on && (!trig_hit || (drop < $signed(owd_pkg::VAIN_DROP_LIMIT)));
          vain_new = vain_hit ? st.vain_count + 1'b1 : '0;
          st_nxt.vain_count = vain_new;
          if (vain_new > owd_pkg::VAIN_COUNT_LIMIT) begin
            st_nxt.open_flag = 1'b1;
            st_nxt.baseline  = temperature;
            st_nxt.watching  = 1'b0;
            mode   = owd_pkg::MODE_ANTIFREEZE;
            target = cfg.antifreeze_target;
          end
        end
      end
    end
  end

  assign res.window_is_open = st_nxt.open_flag;
  assign res.mode_change    = mode;
  assign res.new_target     = target;

endmodule

// ----- verif/tb_open_window_detector_top.sv -----
module tb_open_window_detector_top;

  localparam int VAIN_DROP = 20;  // a heated sample is vain below this drop
  localparam int VAIN_RUN  = 5;   // more vain samples than this declare open

  class verdict_tracker;
    owd_pkg::cfg_t            regs;
    bit                       open_flag;
    bit                       watching;
    int unsigned              tick_count;
    int                       baseline;
    bit [owd_pkg::VAIN_W-1:0] vain_count;
    owd_pkg::result_t         expected_verdicts[$];
    int                       mismatches;

    function new();
      regs.enable            = 1'b0;
      regs.comfort_target    = owd_pkg::RST_COMFORT;
      regs.antifreeze_target = owd_pkg::RST_ANTIFREEZE;
      regs.trigger_delta     = owd_pkg::RST_TRIGGER;
      regs.open_delta        = owd_pkg::RST_OPEN;
      regs.close_delta       = owd_pkg::RST_CLOSE;
      regs.sample_ticks      = owd_pkg::RST_SAMPLE;
      regs.watch_ticks       = owd_pkg::RST_WATCH;
      open_flag  = 1'b0;
      watching   = 1'b0;
      tick_count = 32'(owd_pkg::TICK_RESET);
      baseline   = 0;
      vain_count = '0;
      mismatches = 0;
    endfunction

    function void restart_at(int t);
      baseline   = t;
      watching   = 1'b0;
      tick_count = 0;
    endfunction

    function void declare_verdict(bit now_open, int t, inout owd_pkg::result_t r);
      open_flag     = now_open;
      r.mode_change = now_open ? owd_pkg::MODE_ANTIFREEZE : owd_pkg::MODE_COMFORT;
      r.new_target  = now_open ? regs.antifreeze_target : regs.comfort_target;
      restart_at(t);
    endfunction

    function void advance_tick(int t, bit heating, inout owd_pkg::result_t r);
      int trig;
      int open_lim;
      int close_lim;
      trig      = int'(regs.trigger_delta);
      open_lim  = int'(regs.open_delta);
      close_lim = int'(regs.close_delta);
      if (watching) begin
        if (tick_count < 32'(regs.watch_ticks)) begin
          if (!open_flag && baseline - t > open_lim)
            declare_verdict(1'b1, t, r);
          else if (open_flag && t - baseline > close_lim)
            declare_verdict(1'b0, t, r);
          // a verdict restarts the counter, which still advances here
          tick_count = (tick_count + 1) & 32'hFFFF;
        end else begin
          restart_at(t);
        end
      end else if (tick_count < 32'(regs.sample_ticks)) begin
        tick_count = (tick_count + 1) & 32'hFFFF;
      end else if (!open_flag) begin
        if (baseline - t > trig) watching = 1'b1;
        else baseline = t;
        if (heating && baseline - t < VAIN_DROP) vain_count = vain_count + 1'b1;
        else vain_count = '0;
        if (int'(vain_count) > VAIN_RUN) declare_verdict(1'b1, t, r);
        tick_count = 0;
      end else begin
        if (t - baseline > trig) watching = 1'b1;
        else baseline = t;
        tick_count = 0;
      end
    endfunction

    function void note_reading(bit act, logic signed [owd_pkg::TEMP_W-1:0] temp, bit heat);
      owd_pkg::result_t r;
      int t;
      t                = int'(temp);
      r.window_is_open = 1'b0;
      r.mode_change    = owd_pkg::MODE_NONE;
      r.new_target     = '0;
      if (act) baseline = t;
      else if (regs.enable) advance_tick(t, heat, r);
      r.window_is_open = open_flag;
      expected_verdicts.push_back(r);
    endfunction

    function void check_verdict(logic [15:0] data);
      owd_pkg::result_t want;
      if (expected_verdicts.size() == 0) begin
        $error("result item with nothing pending, tdata %h", data);
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (data[0] !== want.window_is_open) begin
        $error("window_is_open: expected %0d, got %0d", want.window_is_open, data[0]);
        mismatches++;
      end
      if (data[2:1] !== want.mode_change) begin
        $error("mode_change: expected %0d, got %0d", want.mode_change, data[2:1]);
        mismatches++;
      end
      if (data[10:3] !== want.new_target) begin
        $error("new_target: expected %0d, got %0d", want.new_target, data[10:3]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  verdict_tracker sb = new();

  int            send_idle_pct;
  int            stall_pct;
  int            room;
  int            heat_pct;
  bit            act;
  bit            heat;
  int            pick;
  owd_pkg::cfg_t regs;

  open_window_detector_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // note accepted inputs before checking results of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_reading(in_tuser, in_tdata[owd_pkg::TEMP_W-1:0], in_tdata[owd_pkg::TEMP_W]);
      if (out_tvalid && out_tready)
        sb.check_verdict(out_tdata);
    end
  end

  task automatic send_reading(input bit a, input int temp, input bit h);
    bit gap;
    gap = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!gap) in_tvalid <= 1'b0;
      gap = 1'b1;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= a;
    in_tdata  <= {4'b0, h, owd_pkg::TEMP_W'(temp)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_verdicts.size() != 0);
  endtask

  task automatic program_regs(input owd_pkg::cfg_t c);
    owd_pkg::reg_idx_t idx;
    logic [15:0]       val;
    for (int i = 0; i < 8; i++) begin
      idx = owd_pkg::reg_idx_t'(i);
      case (idx)
        owd_pkg::REG_ENABLE:     val = 16'(c.enable);
        owd_pkg::REG_COMFORT:    val = 16'(c.comfort_target);
        owd_pkg::REG_ANTIFREEZE: val = 16'(c.antifreeze_target);
        owd_pkg::REG_TRIGGER:    val = 16'(c.trigger_delta);
        owd_pkg::REG_OPEN:       val = 16'(c.open_delta);
        owd_pkg::REG_CLOSE:      val = 16'(c.close_delta);
        owd_pkg::REG_SAMPLE:     val = c.sample_ticks;
        owd_pkg::REG_WATCH:      val = c.watch_ticks;
        default:                 val = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= val;
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    sb.regs = c;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= 1'b0;
    out_tready    <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= owd_pkg::REG_ENABLE;
    cfg_wdata     <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: detection off, capture still works
    send_reading(1'b1, -500, 1'b0);
    send_reading(1'b0, 1000, 1'b1);
    drain_results();

    regs.enable            = 1'b1;
    regs.comfort_target    = 8'd255;
    regs.antifreeze_target = 8'd0;
    regs.trigger_delta     = 10'd10;
    regs.open_delta        = 10'd50;
    regs.close_delta       = 10'd50;
    regs.sample_ticks      = 16'd0;
    regs.watch_ticks       = 16'd3;
    program_regs(regs);

    // drop opens a watch, a larger drop declares open
    send_reading(1'b1, 200, 1'b0);
    send_reading(1'b0, 200, 1'b0);
    send_reading(1'b0, 185, 1'b0);
    send_reading(1'b0, 140, 1'b1);
    // rise while open starts a watch that expires without a verdict
    send_reading(1'b0, 155, 1'b0);
    repeat (4) send_reading(1'b0, 150, 1'b0);
    send_reading(1'b0, 165, 1'b0);
    send_reading(1'b0, 220, 1'b0);
    // heating without warming declares open; the count survives the close
    repeat (6) send_reading(1'b0, 220, 1'b1);
    send_reading(1'b0, 235, 1'b0);
    send_reading(1'b0, 300, 1'b0);
    send_reading(1'b0, 300, 1'b1);
    send_reading(1'b1, 1000, 1'b1);
    send_reading(1'b0, -500, 1'b0);
    send_reading(1'b0, 1000, 1'b1);
    send_reading(1'b0, 1000, 1'b1);
    drain_results();

    room = 200;
    for (int p = 0; p < 24; p++) begin
      if (p == 0) begin
        regs = '0;
        regs.enable = 1'b1;
      end else if (p == 1) begin
        regs.enable            = 1'b1;
        regs.comfort_target    = 8'd255;
        regs.antifreeze_target = 8'd255;
        regs.trigger_delta     = 10'd1000;
        regs.open_delta        = 10'd1000;
        regs.close_delta       = 10'd1000;
        regs.sample_ticks      = 16'hFFFF;
        regs.watch_ticks       = 16'hFFFF;
      end else begin
        regs.enable            = ($urandom_range(5) != 0);
        regs.comfort_target    = 8'($urandom_range(255));
        regs.antifreeze_target = 8'($urandom_range(255));
        case ($urandom_range(3))
          0:       regs.trigger_delta = 10'($urandom_range(20));
          1:       regs.trigger_delta = 10'($urandom_range(60));
          2:       regs.trigger_delta = 10'($urandom_range(1000));
          default: regs.trigger_delta = 10'd0;
        endcase
        regs.open_delta  = 10'(($urandom_range(7) == 0) ? $urandom_range(1000)
                                                        : $urandom_range(90));
        regs.close_delta = 10'(($urandom_range(7) == 0) ? $urandom_range(1000)
                                                        : $urandom_range(90));
        regs.sample_ticks = 16'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                         : $urandom_range(4));
        regs.watch_ticks  = 16'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                         : $urandom_range(8));
      end
      program_regs(regs);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      heat_pct = ($urandom_range(1) != 0) ? 90 : 35;

      for (int n = 0; n < 76; n++) begin
        act  = ($urandom_range(99) < 10);
        heat = ($urandom_range(99) < heat_pct);
        pick = $urandom_range(99);
        // mostly a drifting room with occasional sharp swings and jumps
        if (pick < 55)
          room = room + int'($urandom_range(30)) - 15;
        else if (pick < 88)
          room = room + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(120, 30));
        else
          room = int'($urandom_range(1500)) - 500;
        if (room < -500) room = -500;
        if (room > 1000) room = 1000;
        send_reading(act, room, heat);
      end
      drain_results();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_verdicts.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
